@@ design/zpl_pkg.sv @@
// zpl_pkg: shared types, codes and filter constants for the zero-phase low-pass unit
// no dependencies
`timescale 1ns / 1ps
package zpl_pkg;
   localparam int MAX_SAMPLES = 2048;
   localparam int AW = $clog2(MAX_SAMPLES);
   localparam int LW = AW + 1;
   localparam int NTAP = 6;
   localparam int NEXT = 10;
   localparam int MIN_SET = 11;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_NONE = 2'd2;
   localparam logic [1:0] ST_TRUNC = 2'd3;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_LAST = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      logic signed [23:0] value;
      logic [10:0] index;
   } cmd_type;

   function automatic logic signed [31:0] coef(input logic [3:0] k);
      case (k)
         4'd0: coef = 32'sd537986;
         4'd1: coef = 32'sd2689928;
         4'd2: coef = 32'sd5379855;
         4'd3: coef = 32'sd5379855;
         4'd4: coef = 32'sd2689928;
         4'd5: coef = 32'sd537986;
         4'd6: coef = 32'sd738852791;
         4'd7: coef = -32'sd896230310;
         4'd8: coef = 32'sd573714498;
         4'd9: coef = -32'sd191542659;
         4'd10: coef = 32'sd26425600;
         default: coef = 32'sd0;
      endcase
   endfunction
endpackage

@@ design/zero_phase_iir_lowpass_unit.sv @@
// zero_phase_iir_lowpass_unit: top level, front queue plus filter back end
// depends on zpl_pkg, zpl_front, zpl_back
`timescale 1ns / 1ps
// Loads a set of signed 24-bit samples (req_tuser 0), the word with req_tlast
// closing the set and, for a set of at least 11 samples, starting a forward then
// backward 5th-order low-pass pass. Each pass filters set length + 10 samples
// on the single shared multiply-accumulate unit doing eleven products per sample;
// loads are taken back to back while the back end is idle, and reads (req_tuser 1)
// pass the queue and the read state before rsp_tvalid is raised.
// A four-word queue lets requests be accepted while filtering is under way.
module zero_phase_iir_lowpass_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic req_tlast,
   input  logic req_tuser,          // req_type
   input  logic [39:0] req_tdata,   // sample_value[23:0], read_index[34:24]
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [31:0] rsp_tdata    // filtered_value[23:0], read_status[25:24]
);
   logic q_valid, q_ready;
   zpl_pkg::cmd_type q_cmd;
   logic [23:0] val;
   logic [1:0] sts;

   zpl_front u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_kind(req_tuser), .in_last(req_tlast), .in_data(req_tdata),
      .q_valid, .q_ready, .q_cmd);

   zpl_back u_back (
      .clock, .reset, .q_valid, .q_ready, .q_cmd,
      .o_valid(rsp_tvalid), .o_ready(rsp_tready), .o_value(val), .o_status(sts));

   assign rsp_tdata = {6'd0, sts, val};

`ifndef SYNTHESIS
   // a pending word holds steady while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed under stall");
   // an out-of-range or empty read carries zero data
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[25:24] == zpl_pkg::ST_RANGE ||
                     rsp_tdata[25:24] == zpl_pkg::ST_NONE) |-> rsp_tdata[23:0] == 24'd0)
      else $error("nonzero data on failed read");
`endif
endmodule

@@ design/zpl_front.sv @@
// zpl_front: accepts request words, classifies them and queues commands
// depends on zpl_pkg
`timescale 1ns / 1ps
module zpl_front (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic in_kind,
   input  logic in_last,
   input  logic [39:0] in_data,
   output logic q_valid,
   input  logic q_ready,
   output zpl_pkg::cmd_type q_cmd
);
   zpl_pkg::cmd_type mem_ff [4];
   logic [1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0] cnt_ff, cnt_in;
   zpl_pkg::cmd_type c;
   logic push, pop;

   always_comb begin
      c.value = in_data[23:0];
      c.index = in_data[34:24];
      if (in_kind) c.op = zpl_pkg::OP_READ;
      else if (in_last) c.op = zpl_pkg::OP_LAST;
      else c.op = zpl_pkg::OP_LOAD;
   end

   assign in_ready = cnt_ff != 3'd4;
   assign push = in_valid && in_ready;
   assign q_valid = cnt_ff != 3'd0;
   assign pop = q_valid && q_ready;
   assign q_cmd = mem_ff[rp_ff];
   assign wp_in = wp_ff + {1'b0, push};
   assign rp_in = rp_ff + {1'b0, pop};
   assign cnt_in = cnt_ff + {2'b0, push} - {2'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= c;
   end
endmodule

@@ design/zpl_back.sv @@
// zpl_back: sample stores, two-pass filter sequencer with shared mac, read path
// depends on zpl_pkg
`timescale 1ns / 1ps
module zpl_back (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   output logic q_ready,
   input  zpl_pkg::cmd_type q_cmd,
   output logic o_valid,
   input  logic o_ready,
   output logic [23:0] o_value,
   output logic [1:0] o_status
);
   localparam int AW = zpl_pkg::AW;
   localparam int LW = zpl_pkg::LW;
   localparam logic [2:0] S_IDLE = 3'd0, S_FETCH = 3'd1, S_WAIT = 3'd2,
      S_MAC = 3'd3, S_DONE = 3'd4, S_READ = 3'd5;

   logic signed [23:0] smem [zpl_pkg::MAX_SAMPLES];
   logic signed [31:0] pmem [zpl_pkg::MAX_SAMPLES];
   logic signed [23:0] rmem [zpl_pkg::MAX_SAMPLES];

   logic [2:0] st_ff, st_in;
   logic [LW-1:0] len_ff, len_in;
   logic rdy_ff, rdy_in, trunc_ff, trunc_in, closed_ff, closed_in;
   logic rev_ff, rev_in;
   logic [LW:0] n_ff, n_in;
   logic [3:0] j_ff, j_in;
   logic signed [31:0] xh_ff [6];
   logic signed [31:0] yh_ff [5];
   logic signed [63:0] acc_ff, acc_in, prod_ff;
   logic signed [23:0] sq_ff;
   logic signed [31:0] pq_ff, x_cur;
   logic signed [23:0] rq_ff;
   logic [10:0] ridx_ff;
   logic ov_ff, ov_in;
   logic [23:0] ovl_ff, ovl_in;
   logic [1:0] ost_ff, ost_in;
   logic signed [31:0] opnd, y;
   logic signed [63:0] rnd, rr;
   logic [LW:0] k, kk;
   logic signed [32:0] yr;
   logic last_n;

   // element index of the extended sequence
   assign k = (n_ff < (LW+1)'(zpl_pkg::NEXT)) ? (LW+1)'(zpl_pkg::NEXT) - n_ff
                                              : n_ff - (LW+1)'(zpl_pkg::NEXT);
   assign kk = (LW+1)'(len_ff) - (LW+1)'(1) - k;
   assign last_n = n_ff == (LW+1)'(len_ff) + (LW+1)'(zpl_pkg::NEXT) - (LW+1)'(1);
   assign x_cur = rev_ff ? pq_ff : {sq_ff, 8'd0};
   assign opnd = (j_ff < 4'd6) ? xh_ff[j_ff[2:0]] :
                 (j_ff < 4'd11) ? yh_ff[3'(j_ff - 4'd6)] : 32'sd0;
   assign rnd = acc_ff + 64'sd134217728;
   assign rr = rnd >>> 28;
   assign y = (n_ff < (LW+1)'(zpl_pkg::NTAP)) ? xh_ff[0] :
              (rr > 64'sd2147483647) ? 32'sh7fffffff :
              (rr < -64'sd2147483648) ? 32'sh80000000 : rr[31:0];
   assign yr = (33'(y) + 33'sd128) >>> 8;

   always_ff @(posedge clock) begin
      if (st_ff == S_IDLE && q_valid && q_cmd.op != zpl_pkg::OP_READ &&
          (closed_ff || len_ff < LW'(zpl_pkg::MAX_SAMPLES)))
         smem[closed_ff ? '0 : len_ff[AW-1:0]] <= q_cmd.value;
      sq_ff <= smem[k[AW-1:0]];
      pq_ff <= pmem[kk[AW-1:0]];
      if (st_ff == S_IDLE) rq_ff <= rmem[q_cmd.index[AW-1:0]];
      if (st_ff == S_DONE && n_ff >= (LW+1)'(zpl_pkg::NEXT)) begin
         if (!rev_ff) pmem[k[AW-1:0]] <= y;
         else rmem[kk[AW-1:0]] <= (yr > 33'sd8388607) ? 24'sh7fffff :
                                 (yr < -33'sd8388608) ? 24'sh800000 : yr[23:0];
      end
      prod_ff <= zpl_pkg::coef(j_ff) * opnd;
      // histories start from zero on every pass
      if (st_ff == S_IDLE || (st_ff == S_DONE && last_n)) begin
         for (int i = 0; i < 6; i++) xh_ff[i] <= '0;
         for (int i = 0; i < 5; i++) yh_ff[i] <= '0;
      end else begin
         if (st_ff == S_WAIT) begin
            for (int i = 5; i > 0; i--) xh_ff[i] <= xh_ff[i-1];
            xh_ff[0] <= x_cur;
         end
         if (st_ff == S_DONE) begin
            for (int i = 4; i > 0; i--) yh_ff[i] <= yh_ff[i-1];
            yh_ff[0] <= y;
         end
      end
      if (st_ff == S_IDLE) ridx_ff <= q_cmd.index;
      ovl_ff <= ovl_in;
      ost_ff <= ost_in;
   end

   assign q_ready = (st_ff == S_IDLE) && !(q_cmd.op == zpl_pkg::OP_READ && ov_ff);
   assign o_valid = ov_ff;
   assign o_value = ovl_ff;
   assign o_status = ost_ff;

   always_comb begin
      st_in = st_ff; len_in = len_ff; rdy_in = rdy_ff; trunc_in = trunc_ff;
      closed_in = closed_ff; rev_in = rev_ff; n_in = n_ff; j_in = j_ff;
      acc_in = acc_ff; ov_in = ov_ff; ovl_in = ovl_ff; ost_in = ost_ff;
      if (ov_ff && o_ready) ov_in = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            if (q_valid && q_ready) begin
               if (q_cmd.op == zpl_pkg::OP_READ) begin
                  st_in = S_READ;
               end else begin
                  if (closed_ff) begin
                     len_in = '0; rdy_in = 1'b0; trunc_in = 1'b0; closed_in = 1'b0;
                  end
                  if (len_in < LW'(zpl_pkg::MAX_SAMPLES)) len_in = len_in + LW'(1);
                  else trunc_in = 1'b1;
                  if (q_cmd.op == zpl_pkg::OP_LAST) begin
                     closed_in = 1'b1;
                     if (len_in >= LW'(zpl_pkg::MIN_SET)) begin
                        st_in = S_FETCH; rev_in = 1'b0; n_in = '0;
                     end
                  end
               end
            end
         end
         S_FETCH: st_in = S_WAIT;
         S_WAIT: begin
            st_in = S_MAC; j_in = '0; acc_in = '0;
         end
         S_MAC: begin
            // products are registered, so each reaches the accumulator in the cycle after its coefficient index
            j_in = j_ff + 4'd1;
            if (j_ff != 4'd0) acc_in = acc_ff + prod_ff;
            if (j_ff == 4'd11) st_in = S_DONE;
         end
         S_DONE: begin
            if (last_n) begin
               n_in = '0;
               if (rev_ff) begin
                  st_in = S_IDLE; rdy_in = 1'b1;
               end else begin
                  rev_in = 1'b1; st_in = S_FETCH;
               end
            end else begin
               n_in = n_ff + (LW+1)'(1); st_in = S_FETCH;
            end
         end
         S_READ: begin
            st_in = S_IDLE; ov_in = 1'b1;
            if (!rdy_ff) begin
               ovl_in = '0; ost_in = zpl_pkg::ST_NONE;
            end else if (LW'(ridx_ff) >= len_ff) begin
               ovl_in = '0; ost_in = zpl_pkg::ST_RANGE;
            end else begin
               ovl_in = rq_ff; ost_in = trunc_ff ? zpl_pkg::ST_TRUNC : zpl_pkg::ST_OK;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; len_ff <= '0; rdy_ff <= 1'b0; trunc_ff <= 1'b0;
         closed_ff <= 1'b1; rev_ff <= 1'b0; n_ff <= '0; j_ff <= '0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; len_ff <= len_in; rdy_ff <= rdy_in; trunc_ff <= trunc_in;
         closed_ff <= closed_in; rev_ff <= rev_in; n_ff <= n_in; j_ff <= j_in;
         ov_ff <= ov_in;
      end
      acc_ff <= acc_in;
   end
endmodule
